// File: hdl/lcs_length_core_assert.svh
// Assertion macros shared by the lcs_length_core RTL.
// Each macro samples on the rising edge of clk and is disabled during reset.
`ifndef LCS_LENGTH_CORE_ASSERT_SVH
`define LCS_LENGTH_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define LCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication from a condition in this cycle to one in the next cycle.
`define LCS_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// File: hdl/lcs_pkg.sv
package lcs_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int CH_W        = 8;
    localparam int LEN_OUT_W   = 7;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_STREAM = 1'b1;

    typedef struct packed {
        logic            op;
        logic [CH_W-1:0] ch;
        logic            last;
    } item_t;

    typedef struct packed {
        logic [LEN_OUT_W-1:0] lcs_len;
        logic                 truncated;
    } result_t;

    // One character of the streamed string as it moves along the chain.
    typedef struct packed {
        logic            valid;
        logic            last;
        logic [CH_W-1:0] ch;
    } tok_t;

    typedef struct packed {
        logic advance;
        logic clear;
    } cell_ctrl_t;

endpackage

// File: hdl/lcs_length_core.sv
// lcs_length_core computes the length of the longest common subsequence of two byte strings.
// Load the second string first with op = 0, one character per transaction, marking the
// final one with last; up to MAX_LEN characters are kept, further ones are dropped and the
// result reports truncated. Then stream the first string with op = 1; its last character
// produces one result. The stored string lives in a row of MAX_LEN cells, one character
// each, and a streamed character moves one cell per cycle unless the row is stalled, so
// the first string is taken at one character per cycle while the row is not stalled, and
// its result is registered once its last character reaches the end of the row. The row
// stalls, and stops taking characters, only while a result waits and the last character
// of the next string has reached the end of the row. A load character is taken only once
// no streamed character is left in the cell row; further load characters then go at one
// per cycle. Streamed characters that arrive during an unfinished load are taken and
// ignored.
module lcs_length_core #(
    parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  lcs_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output lcs_pkg::result_t result
);
    import lcs_pkg::*;

    localparam int SCORE_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = $clog2(MAX_LEN);

    logic [SCORE_W-1:0] second_len_reg;
    logic [SCORE_W-1:0] second_len_next;
    logic               load_done_reg;
    logic               load_done_next;
    logic               overflow_reg;
    logic               overflow_next;
    logic               result_valid_reg;
    result_t            result_reg;

    logic               item_acc;
    logic               load_acc;
    logic               inject;
    logic               load_we;
    logic [SCORE_W-1:0] len_base;
    logic               advance;
    logic               chain_empty;
    logic               tail_last;
    cell_ctrl_t         ctrl;

    tok_t               tok_c  [MAX_LEN+1];
    logic [SCORE_W-1:0] diag_c [MAX_LEN+1];
    logic [SCORE_W-1:0] left_c [MAX_LEN+1];
    logic [MAX_LEN-1:0] tok_v;
    logic [SCORE_W+LEN_OUT_W-1:0] tail_wide;

    assign tail_last   = tok_c[MAX_LEN].valid && tok_c[MAX_LEN].last;
    assign advance     = !(tail_last && result_valid_reg && !result_ready);
    assign chain_empty = ~|tok_v;
    assign item_ready  = advance && ((item.op == OP_STREAM) || chain_empty);
    assign item_acc    = item_valid && item_ready;
    assign load_acc    = item_acc && (item.op == OP_LOAD);
    assign inject      = item_acc && (item.op == OP_STREAM) && load_done_reg;
    assign len_base    = load_done_reg ? '0 : second_len_reg;
    assign load_we     = load_acc && (len_base < SCORE_W'(MAX_LEN));

    assign ctrl.advance = advance;
    assign ctrl.clear   = load_acc && item.last;

    always_comb
    begin
        second_len_next = second_len_reg;
        load_done_next  = load_done_reg;
        overflow_next   = overflow_reg;
        if (load_acc)
        begin
            // A load character after a finished load opens a new second string.
            second_len_next = len_base;
            load_done_next  = 1'b0;
            if (load_done_reg)
            begin
                overflow_next = 1'b0;
            end
            if (load_we)
            begin
                second_len_next = len_base + SCORE_W'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
            if (item.last)
            begin
                load_done_next = 1'b1;
            end
        end
    end

    assign tok_c[0].valid = inject;
    assign tok_c[0].last  = item.last;
    assign tok_c[0].ch    = item.ch;
    assign diag_c[0]      = '0;
    assign left_c[0]      = '0;

    for (genvar j = 0; j < MAX_LEN; j++)
    begin : g_cell
        logic wr_en;
        logic active;

        assign wr_en    = load_we && (len_base[IDX_W-1:0] == IDX_W'(j));
        assign active   = SCORE_W'(j) < second_len_reg;
        assign tok_v[j] = tok_c[j+1].valid;

        lcs_cell #(
            .SCORE_W (SCORE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .wr_en    (wr_en),
            .wr_ch    (item.ch),
            .active   (active),
            .tok_in   (tok_c[j]),
            .diag_in  (diag_c[j]),
            .left_in  (left_c[j]),
            .tok_out  (tok_c[j+1]),
            .diag_out (diag_c[j+1]),
            .left_out (left_c[j+1])
        );
    end

    assign tail_wide = {{LEN_OUT_W{1'b0}}, left_c[MAX_LEN]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_len_reg   <= '0;
            load_done_reg    <= 1'b1;
            overflow_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            second_len_reg <= second_len_next;
            load_done_reg  <= load_done_next;
            overflow_reg   <= overflow_next;
            if (advance && tail_last)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail_last)
        begin
            result_reg.lcs_len   <= tail_wide[LEN_OUT_W-1:0];
            result_reg.truncated <= overflow_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`include "lcs_length_core_assert.svh"

    `LCS_ASSERT(a_load_on_empty_chain, !load_acc || chain_empty, "load taken with chain busy")
    `LCS_ASSERT(a_len_in_range, second_len_reg <= SCORE_W'(MAX_LEN), "stored length too big")
    `LCS_ASSERT(a_stall_only_on_result, advance || (tail_last && result_valid_reg), "bad stall")
    `LCS_ASSERT_NEXT(a_stall_keeps_tail, !advance, tail_last, "stalled tail lost")

endmodule

// File: hdl/lcs_cell.sv
module lcs_cell #(
    parameter int SCORE_W = lcs_pkg::LEN_OUT_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lcs_pkg::cell_ctrl_t       ctrl,
    input  logic                      wr_en,
    input  logic [lcs_pkg::CH_W-1:0]  wr_ch,
    input  logic                      active,
    input  lcs_pkg::tok_t             tok_in,
    input  logic [SCORE_W-1:0]        diag_in,
    input  logic [SCORE_W-1:0]        left_in,
    output lcs_pkg::tok_t             tok_out,
    output logic [SCORE_W-1:0]        diag_out,
    output logic [SCORE_W-1:0]        left_out
);
    import lcs_pkg::*;

    logic [CH_W-1:0]    ch_reg;
    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] score_next;
    tok_t               tok_reg;
    logic [SCORE_W-1:0] diag_reg;
    logic [SCORE_W-1:0] left_reg;
    logic [SCORE_W-1:0] up;
    logic [SCORE_W-1:0] v;

    always_comb
    begin
        up = score_reg;
        if (ch_reg == tok_in.ch)
        begin
            v = diag_in + SCORE_W'(1);
        end
        else
        begin
            v = (up > left_in) ? up : left_in;
        end
        score_next = score_reg;
        if (ctrl.clear)
        begin
            score_next = '0;
        end
        else if (ctrl.advance && tok_in.valid && active)
        begin
            // The final character of a string leaves the row cleared behind it.
            score_next = tok_in.last ? '0 : v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            score_reg <= score_next;
            if (ctrl.advance)
            begin
                tok_reg <= tok_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ch_reg <= wr_ch;
        end
        if (ctrl.advance)
        begin
            diag_reg <= up;
            // Cells past the stored string pass the running score through.
            left_reg <= active ? v : left_in;
        end
    end

    assign tok_out  = tok_reg;
    assign diag_out = diag_reg;
    assign left_out = left_reg;

endmodule
